FILE: sv/osl_pkg.sv
// osl_pkg: shared types, character codes and keyword tables for the opcode spec lexer
// used by osl_front, osl_queue, osl_back and opcode_spec_lexer; no dependencies
package osl_pkg;

    // depth of the word queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // keyword table size
    localparam int NUM_KW = 6;
    localparam int KW_MAX = 9;

    // lexer modes
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_ZERO,
        MODE_HEXS,
        MODE_HEX,
        MODE_OCT,
        MODE_DEC,
        MODE_FLOAT,
        MODE_WORD,
        MODE_HALT
    } mode_t;

    // token kinds
    typedef enum logic [3:0] {
        KIND_MINUS     = 4'd0,
        KIND_SEMI      = 4'd1,
        KIND_OPEN      = 4'd2,
        KIND_CLOSE     = 4'd3,
        KIND_UINT      = 4'd4,
        KIND_FLOAT     = 4'd5,
        KIND_SBYTE     = 4'd6,
        KIND_SEND      = 4'd7,
        KIND_PREFIX    = 4'd8,
        KIND_OPCODE    = 4'd9,
        KIND_UNKNOWN   = 4'd10,
        KIND_SILENT    = 4'd11,
        KIND_EXCEPTION = 4'd12,
        KIND_UD        = 4'd13,
        KIND_ERROR     = 4'd14,
        KIND_DONE      = 4'd15
    } kind_t;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // classified input word as it travels through the queue
    typedef struct packed {
        logic       eoi;
        logic [7:0] raw;
        logic [7:0] upper;
        logic       is_ws;
        logic       is_digit;
        logic       is_alpha;
        logic       is_hex;
        logic [3:0] hex_val;
    } char_t;

    // one result word
    typedef struct packed {
        kind_t       kind;
        logic [63:0] value;
        logic [7:0]  sbyte;
        logic        last;
    } result_t;

    // keyword spellings, upper case, zero padded
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX] = '{
        '{8'h50, 8'h52, 8'h45, 8'h46, 8'h49, 8'h58, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h50, 8'h43, 8'h4F, 8'h44, 8'h45, 8'h00, 8'h00, 8'h00},
        '{8'h55, 8'h4E, 8'h4B, 8'h4E, 8'h4F, 8'h57, 8'h4E, 8'h00, 8'h00},
        '{8'h53, 8'h49, 8'h4C, 8'h45, 8'h4E, 8'h54, 8'h00, 8'h00, 8'h00},
        '{8'h45, 8'h58, 8'h43, 8'h45, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E},
        '{8'h55, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd6, 4'd7, 4'd6, 4'd9, 4'd2};

    // keyword character at a position, zero past its end
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if ((int'(k) < NUM_KW) && (int'(pos) < KW_MAX))
        begin
            c = KW_TEXT[k][pos];
        end
        return c;
    endfunction

    // token kind of a keyword index
    function automatic kind_t kw_kind(input logic [2:0] k);
        kind_t r;
        unique case (k)
            3'd0:    r = KIND_PREFIX;
            3'd1:    r = KIND_OPCODE;
            3'd2:    r = KIND_UNKNOWN;
            3'd3:    r = KIND_SILENT;
            3'd4:    r = KIND_EXCEPTION;
            3'd5:    r = KIND_UD;
            default: r = KIND_ERROR;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/opcode_spec_lexer.sv
// opcode_spec_lexer: accepted words pass through the queue to the back stage. throughput
// is one input word per cycle while in_stall is low; the back stage emits one result per
// cycle while out_stall is low, so a word that causes two results (token plus a reprocessed
// one, or token plus done) sends both; the queue absorbs bursts. reset is asynchronous,
// active low, and clears lexer state, queue and result buffer at once; no clearing pass.
module opcode_spec_lexer #(
    parameter int QUEUE_DEPTH = osl_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [63:0] token_value,
    output logic [7:0]  string_byte,
    output logic        last_of_item
);

    logic           queue_full;
    logic           push;
    osl_pkg::char_t push_data;
    logic           pop;
    logic           head_valid;
    osl_pkg::char_t head_data;

    // front: handshake and classification
    osl_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .queue_full   (queue_full),
        .push         (push),
        .push_data    (push_data)
    );

    // queue between front and back
    osl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // back: lexer and result buffer
    osl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_value  (token_value),
        .string_byte  (string_byte),
        .last_of_item (last_of_item)
    );

endmodule

FILE: sv/osl_front.sv
// osl_front: input handshake and character classification
// depends on osl_pkg; feeds osl_queue
module osl_front (
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             end_of_input,
    input  logic             queue_full,
    output logic             push,
    output osl_pkg::char_t   push_data
);

    logic is_upper;
    logic is_lower;
    logic is_digit;
    logic is_hex_letter;

    // accept while the queue has room
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // character classes
    assign is_upper      = (data_byte >= osl_pkg::CH_UP_A) && (data_byte <= osl_pkg::CH_UP_Z);
    assign is_lower      = (data_byte >= osl_pkg::CH_LO_A) && (data_byte <= osl_pkg::CH_LO_Z);
    assign is_digit      = (data_byte >= osl_pkg::CH_ZERO) && (data_byte <= osl_pkg::CH_NINE);
    assign is_hex_letter = (push_data.upper >= osl_pkg::CH_UP_A)
                        && (push_data.upper <= osl_pkg::CH_UP_F)
                        && (is_upper || is_lower);

    assign push_data.eoi      = end_of_input;
    assign push_data.raw      = data_byte;
    assign push_data.upper    = is_lower ? (data_byte - osl_pkg::CASE_GAP) : data_byte;
    assign push_data.is_ws    = (data_byte == osl_pkg::CH_TAB) || (data_byte == osl_pkg::CH_LF)
                             || (data_byte == osl_pkg::CH_CR) || (data_byte == osl_pkg::CH_SPACE);
    assign push_data.is_digit = is_digit;
    assign push_data.is_alpha = is_upper || is_lower;
    assign push_data.is_hex   = is_digit || is_hex_letter;

    // digit value, letters a-f have low nibble 1..6
    assign push_data.hex_val  = is_digit ? data_byte[3:0] : (data_byte[3:0] + 4'd9);

endmodule

FILE: sv/osl_queue.sv
// osl_queue: short fifo of classified words between front and back
// depends on osl_pkg
module osl_queue #(
    parameter int DEPTH = osl_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  osl_pkg::char_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output osl_pkg::char_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    osl_pkg::char_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/osl_back.sv
// osl_back: lexer state machine, number accumulator, keyword matcher and result buffer
// depends on osl_pkg; takes words from osl_queue
module osl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  osl_pkg::char_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [3:0]     token_kind,
    output logic [63:0]    token_value,
    output logic [7:0]     string_byte,
    output logic           last_of_item
);

    osl_pkg::mode_t   mode_reg, mode_next;
    logic [63:0]      acc_reg, acc_next;
    logic             frozen_reg, frozen_next;
    logic [3:0]       pos_reg, pos_next;
    logic [5:0]       cand_reg, cand_next;

    osl_pkg::result_t slot0_reg, slot0_next;
    osl_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]       cnt_reg, cnt_next;

    logic [67:0]      acc_shift;
    logic [67:0]      acc_wide;
    logic [63:0]      acc_push;
    logic [5:0]       cand_add;
    logic [5:0]       cand_init;
    logic [3:0]       pos_add;
    logic             fin_ok;
    osl_pkg::kind_t   fin_kind;

    logic [1:0]       nres;
    osl_pkg::kind_t   r0_kind;
    logic [63:0]      r0_value;
    logic [7:0]       r0_sbyte;
    osl_pkg::kind_t   r1_kind;
    logic             reproc;
    logic             ia_emit;
    osl_pkg::kind_t   ia_kind;

    logic             deq;
    logic [1:0]       cnt_after;
    logic [2:0]       cnt_sum;
    osl_pkg::result_t new0;
    osl_pkg::result_t new1;

    // shared accumulator step: acc * base + digit, saturating
    always_comb
    begin
        priority if (mode_reg == osl_pkg::MODE_HEX)
        begin
            acc_shift = {acc_reg, 4'b0000};
        end
        else if ((mode_reg == osl_pkg::MODE_ZERO) || (mode_reg == osl_pkg::MODE_OCT))
        begin
            acc_shift = {1'b0, acc_reg, 3'b000};
        end
        else
        begin
            acc_shift = {3'b000, acc_reg, 1'b0} + {1'b0, acc_reg, 3'b000};
        end
    end

    assign acc_wide = acc_shift + {64'd0, head.hex_val};
    assign acc_push = (|acc_wide[67:64]) ? {64{1'b1}} : acc_wide[63:0];

    // keyword candidate update per letter
    always_comb
    begin
        for (int k = 0; k < osl_pkg::NUM_KW; k++)
        begin
            cand_add[k]  = cand_reg[k] && (osl_pkg::kw_char(3'(k), pos_reg) == head.upper);
            cand_init[k] = (osl_pkg::kw_char(3'(k), 4'd0) == head.upper);
        end
    end

    assign pos_add = (pos_reg == 4'hF) ? pos_reg : (pos_reg + 4'd1);

    // keyword lookup at the end of a word, lowest index wins
    always_comb
    begin
        fin_ok   = 1'b0;
        fin_kind = osl_pkg::KIND_ERROR;
        for (int k = osl_pkg::NUM_KW - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && (pos_reg == osl_pkg::KW_LEN[k]))
            begin
                fin_ok   = 1'b1;
                fin_kind = osl_pkg::kw_kind(3'(k));
            end
        end
    end

    // action of a byte seen in idle
    always_comb
    begin
        ia_emit = 1'b1;
        ia_kind = osl_pkg::KIND_ERROR;
        priority if (head.is_ws)
        begin
            ia_emit = 1'b0;
        end
        else if (head.raw == osl_pkg::CH_MINUS)
        begin
            ia_kind = osl_pkg::KIND_MINUS;
        end
        else if (head.raw == osl_pkg::CH_SEMI)
        begin
            ia_kind = osl_pkg::KIND_SEMI;
        end
        else if (head.raw == osl_pkg::CH_OPEN)
        begin
            ia_kind = osl_pkg::KIND_OPEN;
        end
        else if (head.raw == osl_pkg::CH_CLOSE)
        begin
            ia_kind = osl_pkg::KIND_CLOSE;
        end
        else if ((head.raw == osl_pkg::CH_QUOTE) || head.is_digit || head.is_alpha)
        begin
            ia_emit = 1'b0;
        end
        else
        begin
            ia_kind = osl_pkg::KIND_ERROR;
        end
    end

    // one lexer step for the word at the queue head
    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        frozen_next = frozen_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        nres        = 2'd0;
        r0_kind     = osl_pkg::KIND_DONE;
        r0_value    = '0;
        r0_sbyte    = '0;
        r1_kind     = osl_pkg::KIND_DONE;
        reproc      = 1'b0;

        if (head.eoi)
        begin
            // flush the pending token or report an unfinished one as error, then done
            unique case (mode_reg)
                osl_pkg::MODE_IDLE, osl_pkg::MODE_HALT:
                begin
                end
                osl_pkg::MODE_ZERO, osl_pkg::MODE_HEX, osl_pkg::MODE_OCT, osl_pkg::MODE_DEC:
                begin
                    r0_kind  = osl_pkg::KIND_UINT;
                    r0_value = acc_reg;
                    nres     = 2'd1;
                end
                osl_pkg::MODE_FLOAT:
                begin
                    r0_kind = osl_pkg::KIND_FLOAT;
                    nres    = 2'd1;
                end
                osl_pkg::MODE_WORD:
                begin
                    r0_kind = fin_ok ? fin_kind : osl_pkg::KIND_ERROR;
                    nres    = 2'd1;
                end
                default:
                begin
                    r0_kind = osl_pkg::KIND_ERROR;
                    nres    = 2'd1;
                end
            endcase
            if (nres == 2'd0)
            begin
                r0_kind = osl_pkg::KIND_DONE;
                nres    = 2'd1;
            end
            else
            begin
                r1_kind = osl_pkg::KIND_DONE;
                nres    = 2'd2;
            end
            mode_next   = osl_pkg::MODE_IDLE;
            acc_next    = '0;
            frozen_next = 1'b0;
            pos_next    = '0;
            cand_next   = '1;
        end
        else
        begin
            unique case (mode_reg)
                osl_pkg::MODE_IDLE:
                begin
                    reproc = 1'b1;
                end
                osl_pkg::MODE_STR:
                begin
                    priority if (head.raw == osl_pkg::CH_QUOTE)
                    begin
                        r0_kind   = osl_pkg::KIND_SEND;
                        nres      = 2'd1;
                        mode_next = osl_pkg::MODE_IDLE;
                    end
                    else if (head.raw == osl_pkg::CH_BSLASH)
                    begin
                        mode_next = osl_pkg::MODE_ESC;
                    end
                    else
                    begin
                        r0_kind  = osl_pkg::KIND_SBYTE;
                        r0_sbyte = head.raw;
                        nres     = 2'd1;
                    end
                end
                osl_pkg::MODE_ESC:
                begin
                    if ((head.raw == osl_pkg::CH_BSLASH) || (head.raw == osl_pkg::CH_APOS)
                        || (head.raw == osl_pkg::CH_QUOTE))
                    begin
                        r0_kind   = osl_pkg::KIND_SBYTE;
                        r0_sbyte  = head.raw;
                        nres      = 2'd1;
                        mode_next = osl_pkg::MODE_STR;
                    end
                    else
                    begin
                        r0_kind   = osl_pkg::KIND_ERROR;
                        nres      = 2'd1;
                        mode_next = osl_pkg::MODE_HALT;
                    end
                end
                osl_pkg::MODE_ZERO:
                begin
                    priority if (head.raw == osl_pkg::CH_LO_X)
                    begin
                        mode_next = osl_pkg::MODE_HEXS;
                    end
                    else if (head.is_digit)
                    begin
                        mode_next = osl_pkg::MODE_OCT;
                        if (head.hex_val[3])
                        begin
                            frozen_next = 1'b1;
                        end
                        else
                        begin
                            frozen_next = 1'b0;
                            acc_next    = acc_push;
                        end
                    end
                    else
                    begin
                        r0_kind = osl_pkg::KIND_UINT;
                        nres    = 2'd1;
                        reproc  = 1'b1;
                    end
                end
                osl_pkg::MODE_HEXS:
                begin
                    if (head.is_hex)
                    begin
                        acc_next  = {60'd0, head.hex_val};
                        mode_next = osl_pkg::MODE_HEX;
                    end
                    else
                    begin
                        r0_kind   = osl_pkg::KIND_ERROR;
                        nres      = 2'd1;
                        mode_next = osl_pkg::MODE_HALT;
                    end
                end
                osl_pkg::MODE_HEX:
                begin
                    if (head.is_hex)
                    begin
                        acc_next = acc_push;
                    end
                    else
                    begin
                        r0_kind  = osl_pkg::KIND_UINT;
                        r0_value = acc_reg;
                        nres     = 2'd1;
                        reproc   = 1'b1;
                    end
                end
                osl_pkg::MODE_OCT:
                begin
                    priority if (head.is_digit)
                    begin
                        if (!frozen_reg)
                        begin
                            if (head.hex_val[3])
                            begin
                                frozen_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = acc_push;
                            end
                        end
                    end
                    else if (head.raw == osl_pkg::CH_DOT)
                    begin
                        mode_next = osl_pkg::MODE_FLOAT;
                    end
                    else
                    begin
                        r0_kind  = osl_pkg::KIND_UINT;
                        r0_value = acc_reg;
                        nres     = 2'd1;
                        reproc   = 1'b1;
                    end
                end
                osl_pkg::MODE_DEC:
                begin
                    priority if (head.is_digit)
                    begin
                        acc_next = acc_push;
                    end
                    else if (head.raw == osl_pkg::CH_DOT)
                    begin
                        mode_next = osl_pkg::MODE_FLOAT;
                    end
                    else
                    begin
                        r0_kind  = osl_pkg::KIND_UINT;
                        r0_value = acc_reg;
                        nres     = 2'd1;
                        reproc   = 1'b1;
                    end
                end
                osl_pkg::MODE_FLOAT:
                begin
                    if (!head.is_digit)
                    begin
                        r0_kind = osl_pkg::KIND_FLOAT;
                        nres    = 2'd1;
                        reproc  = 1'b1;
                    end
                end
                osl_pkg::MODE_WORD:
                begin
                    priority if (head.is_alpha)
                    begin
                        cand_next = cand_add;
                        pos_next  = pos_add;
                    end
                    else if (!fin_ok)
                    begin
                        r0_kind   = osl_pkg::KIND_ERROR;
                        nres      = 2'd1;
                        mode_next = osl_pkg::MODE_HALT;
                    end
                    else
                    begin
                        r0_kind = fin_kind;
                        nres    = 2'd1;
                        reproc  = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = osl_pkg::MODE_HALT;
                end
            endcase

            // ending byte handled again as in idle
            if (reproc)
            begin
                priority if (head.is_ws)
                begin
                    mode_next = osl_pkg::MODE_IDLE;
                end
                else if (head.raw == osl_pkg::CH_QUOTE)
                begin
                    mode_next = osl_pkg::MODE_STR;
                end
                else if (head.raw == osl_pkg::CH_ZERO)
                begin
                    mode_next   = osl_pkg::MODE_ZERO;
                    acc_next    = '0;
                    frozen_next = 1'b0;
                end
                else if (head.is_digit)
                begin
                    mode_next = osl_pkg::MODE_DEC;
                    acc_next  = {60'd0, head.hex_val};
                end
                else if (head.is_alpha)
                begin
                    mode_next = osl_pkg::MODE_WORD;
                    pos_next  = 4'd1;
                    cand_next = cand_init;
                end
                else if (ia_kind == osl_pkg::KIND_ERROR)
                begin
                    mode_next = osl_pkg::MODE_HALT;
                end
                else
                begin
                    mode_next = osl_pkg::MODE_IDLE;
                end
                if (ia_emit)
                begin
                    if (nres == 2'd0)
                    begin
                        r0_kind = ia_kind;
                        nres    = 2'd1;
                    end
                    else
                    begin
                        r1_kind = ia_kind;
                        nres    = 2'd2;
                    end
                end
            end
        end
    end

    // result buffer: two words, head in slot 0
    assign deq       = (cnt_reg != 2'd0) && !out_stall;
    assign cnt_after = cnt_reg - {1'b0, deq};
    assign cnt_sum   = {1'b0, cnt_after} + {1'b0, nres};
    assign pop       = head_valid && (cnt_sum <= 3'd2);

    assign new0 = '{kind: r0_kind, value: r0_value, sbyte: r0_sbyte, last: (nres == 2'd1)};
    assign new1 = '{kind: r1_kind, value: 64'd0, sbyte: 8'd0, last: 1'b1};

    always_comb
    begin
        slot0_next = deq ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_after;
        if (pop && (nres != 2'd0))
        begin
            if (cnt_after == 2'd0)
            begin
                slot0_next = new0;
                slot1_next = new1;
            end
            else
            begin
                slot1_next = new0;
            end
            cnt_next = cnt_sum[1:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= osl_pkg::MODE_IDLE;
            acc_reg    <= '0;
            frozen_reg <= 1'b0;
            pos_reg    <= '0;
            cand_reg   <= '1;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg   <= mode_next;
                acc_reg    <= acc_next;
                frozen_reg <= frozen_next;
                pos_reg    <= pos_next;
                cand_reg   <= cand_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid    = (cnt_reg != 2'd0);
    assign token_kind   = slot0_reg.kind;
    assign token_value  = slot0_reg.value;
    assign string_byte  = slot0_reg.sbyte;
    assign last_of_item = slot0_reg.last;

endmodule
